// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("implication check failed");

// next-cycle implication
`define CHK_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/fpa_pkg.sv =====
// Types, codes and constants of the fixed-point ALU.
`default_nettype none
package fpa_pkg;

   localparam int FRAC_DEFAULT  = 8;
   localparam int QUEUE_DEPTH   = 2;
   localparam int SHIFT_W       = 6;

   localparam logic [2:0] CMD_ADD = 3'd0;
   localparam logic [2:0] CMD_SUB = 3'd1;
   localparam logic [2:0] CMD_MUL = 3'd2;
   localparam logic [2:0] CMD_DIV = 3'd3;
   localparam logic [2:0] CMD_INC = 3'd4;
   localparam logic [2:0] CMD_DEC = 3'd5;
   localparam logic [2:0] CMD_CMP = 3'd6;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_OVF  = 2'd1;
   localparam logic [1:0] ST_UNF  = 2'd2;
   localparam logic [1:0] ST_DIV0 = 2'd3;

   typedef struct packed {
      logic [2:0]         command;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } fpa_req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic               less_than;
      logic               equal_to;
      logic               greater_than;
      logic [1:0]         status;
   } fpa_rsp_type;

   // classified item as it waits in the queue
   typedef struct packed {
      logic [31:0]        a;
      logic [31:0]        ua;
      logic [31:0]        ub;
      logic               neg;
      logic               lt;
      logic               eq;
      logic               gt;
      logic [31:0]        result;
      logic [1:0]         status;
      logic               is_mul;
      logic               is_div;
      logic [SHIFT_W-1:0] s;
   } fpa_cls_type;

   // side information carried along the divider stages
   typedef struct packed {
      logic [31:0]        result;
      logic [1:0]         status;
      logic               lt;
      logic               eq;
      logic               gt;
      logic               is_div;
      logic               s_ge;
      logic [SHIFT_W-1:0] s;
      logic               neg;
   } fpa_side_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fpa_qstat_type;

endpackage
`default_nettype wire

// ===== rtl/fixed_point_alu.sv =====
// Accepted items pass through the queue, the p1 and p2 registers, both dividers and the result register.
// Throughput: one item per cycle while no result is stalled; every command runs through the same fixed pipeline.
// The 32-stage quotient divider and the FRAC-stage fraction divider set the depth.
// A two-entry queue decouples the front end; a stalled result freezes the back end.
// Reset (synchronous, active high) empties the queue and clears all valid bits.
`default_nettype none
`include "assert_macros.svh"
module fixed_point_alu #(
   parameter int FRAC = fpa_pkg::FRAC_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  fpa_pkg::fpa_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output fpa_pkg::fpa_rsp_type rsp_data
);

   fpa_pkg::fpa_cls_type   cls;
   fpa_pkg::fpa_cls_type   q_data;
   fpa_pkg::fpa_qstat_type qstat;
   logic                   q_push;
   logic                   q_pop;

   assign req_stall = qstat.full;
   assign q_push    = req_valid && !qstat.full;

   fpa_front #(.FRAC(FRAC)) u_front (
      .req(req_data),
      .cls(cls)
   );

   fpa_queue #(.DEPTH(fpa_pkg::QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(cls),
      .pop      (q_pop),
      .pop_data (q_data),
      .qstat    (qstat)
   );

   fpa_back #(.FRAC(FRAC)) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_data   (q_data),
      .q_empty  (qstat.empty),
      .q_pop    (q_pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   `CHK_IMPLY(a_no_pop_when_held, clock, reset, rsp_valid && rsp_stall, !q_pop)
   `CHK_NEXT(a_push_fills_queue, clock, reset, q_push && qstat.empty && !q_pop, !qstat.empty)

endmodule
`default_nettype wire

// ===== rtl/fpa_front.sv =====
// Front end: decodes an item, finishes the simple commands and prepares divide and multiply.
`default_nettype none
module fpa_front #(
   parameter int FRAC = fpa_pkg::FRAC_DEFAULT
) (
   input  fpa_pkg::fpa_req_type req,
   output fpa_pkg::fpa_cls_type cls
);

   logic [31:0] a;
   logic [31:0] b;
   logic [31:0] ua;
   logic [31:0] ub;
   logic [32:0] sum_w;
   logic [32:0] diff_w;
   logic [fpa_pkg::SHIFT_W-1:0] s_raw;
   logic [fpa_pkg::SHIFT_W-1:0] k;
   logic [fpa_pkg::SHIFT_W-1:0] s_adj;

   assign a  = req.operand_a;
   assign b  = req.operand_b;
   assign ua = a[31] ? (~a + 32'd1) : a;
   assign ub = b[31] ? (~b + 32'd1) : b;
   assign sum_w  = {a[31], a} + {b[31], b};
   assign diff_w = {a[31], a} - {b[31], b};

   // leading zeros of the dividend magnitude
   always_comb begin
      s_raw = fpa_pkg::SHIFT_W'(32);
      for (int i = 0; i < 32; i++) begin
         if (ua[i]) s_raw = fpa_pkg::SHIFT_W'(31 - i);
      end
   end

   // halvings of 2^FRAC/|b| until it reaches one: FRAC minus bit length of |b|-1
   always_comb begin
      k = '0;
      for (int j = 0; j <= FRAC; j++) begin
         if (ub <= (32'd1 << (FRAC - j))) k = fpa_pkg::SHIFT_W'(j);
      end
      s_adj = s_raw;
      if (ub < (32'd1 << FRAC)) begin
         s_adj = (s_raw > k) ? (s_raw - k) : '0;
      end
   end

   always_comb begin
      cls        = '0;
      cls.a      = a;
      cls.ua     = ua;
      cls.ub     = ub;
      cls.neg    = a[31] ^ b[31];
      cls.lt     = req.operand_a < req.operand_b;
      cls.eq     = a == b;
      cls.gt     = req.operand_a > req.operand_b;
      cls.result = a;
      cls.status = fpa_pkg::ST_OK;
      cls.s      = s_adj;
      unique case (req.command)
         fpa_pkg::CMD_ADD: begin
            if (sum_w[32:31] == 2'b01) cls.status = fpa_pkg::ST_OVF;
            else if (sum_w[32:31] == 2'b10) cls.status = fpa_pkg::ST_UNF;
            else cls.result = sum_w[31:0];
         end
         fpa_pkg::CMD_SUB: begin
            if (diff_w[32:31] == 2'b01) cls.status = fpa_pkg::ST_OVF;
            else if (diff_w[32:31] == 2'b10) cls.status = fpa_pkg::ST_UNF;
            else cls.result = diff_w[31:0];
         end
         fpa_pkg::CMD_MUL: begin
            if (a == '0 || b == '0) cls.result = '0;
            else cls.is_mul = 1'b1;
         end
         fpa_pkg::CMD_DIV: begin
            if (b == '0) cls.status = fpa_pkg::ST_DIV0;
            else if (a == '0) cls.result = '0;
            else cls.is_div = 1'b1;
         end
         fpa_pkg::CMD_INC: cls.result = a + 32'd1;
         fpa_pkg::CMD_DEC: cls.result = a - 32'd1;
         default: cls.result = a;
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/fpa_queue.sv =====
// Short queue of classified items between front and back end.
`default_nettype none
module fpa_queue #(
   parameter int DEPTH = fpa_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  fpa_pkg::fpa_cls_type   push_data,
   input  logic                   pop,
   output fpa_pkg::fpa_cls_type   pop_data,
   output fpa_pkg::fpa_qstat_type qstat
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   fpa_pkg::fpa_cls_type slots_ff [0:DEPTH-1];
   logic [PW-1:0] wr_ptr_ff;
   logic [PW-1:0] rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic [PW-1:0] wr_ptr_in;
   logic [PW-1:0] rd_ptr_in;
   logic [CW-1:0] count_in;

   assign qstat.empty = count_ff == '0;
   assign qstat.full  = count_ff == CW'(DEPTH);
   assign pop_data    = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) count_in = count_ff + CW'(1);
      else if (pop && !push) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slots_ff[wr_ptr_ff] <= push_data;
   end

endmodule
`default_nettype wire

// ===== rtl/fpa_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module fpa_div_pipe #(
   parameter int STEPS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [31:0]           in_dividend,
   input  logic [31:0]           in_divisor,
   input  fpa_pkg::fpa_side_type in_side,
   output logic                  out_valid,
   output logic [31:0]           out_quotient,
   output logic [31:0]           out_remainder,
   output logic [31:0]           out_divisor,
   output fpa_pkg::fpa_side_type out_side
);

   logic                  valid_ff [0:STEPS-1];
   logic [31:0]           rem_ff   [0:STEPS-1];
   logic [31:0]           x_ff     [0:STEPS-1];
   logic [31:0]           d_ff     [0:STEPS-1];
   logic [31:0]           q_ff     [0:STEPS-1];
   fpa_pkg::fpa_side_type side_ff  [0:STEPS-1];

   for (genvar k = 0; k < STEPS; k++) begin : gen_step
      logic                  src_v;
      logic [31:0]           src_rem;
      logic [31:0]           src_x;
      logic [31:0]           src_d;
      logic [31:0]           src_q;
      fpa_pkg::fpa_side_type src_side;
      logic [32:0]           trial;
      logic                  ge;
      logic [31:0]           rem_in;
      logic [31:0]           q_in;

      if (k == 0) begin : gen_head
         // bits above the stepped ones form the starting remainder
         assign src_v    = in_valid;
         assign src_rem  = 32'({32'd0, in_dividend} >> STEPS);
         assign src_x    = in_dividend;
         assign src_d    = in_divisor;
         assign src_q    = '0;
         assign src_side = in_side;
      end else begin : gen_link
         assign src_v    = valid_ff[k-1];
         assign src_rem  = rem_ff[k-1];
         assign src_x    = x_ff[k-1];
         assign src_d    = d_ff[k-1];
         assign src_q    = q_ff[k-1];
         assign src_side = side_ff[k-1];
      end

      assign trial  = {src_rem, src_x[STEPS-1-k]};
      assign ge     = trial >= {1'b0, src_d};
      assign rem_in = ge ? 32'(trial - {1'b0, src_d}) : trial[31:0];
      assign q_in   = {src_q[30:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            x_ff[k]    <= src_x;
            d_ff[k]    <= src_d;
            q_ff[k]    <= q_in;
            side_ff[k] <= src_side;
         end
      end
   end

   assign out_valid     = valid_ff[STEPS-1];
   assign out_quotient  = q_ff[STEPS-1];
   assign out_remainder = rem_ff[STEPS-1];
   assign out_divisor   = d_ff[STEPS-1];
   assign out_side      = side_ff[STEPS-1];

endmodule
`default_nettype wire

// ===== rtl/fpa_back.sv =====
// Back end: multiply, two-pass divide and the result register.
`default_nettype none
module fpa_back #(
   parameter int FRAC = fpa_pkg::FRAC_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fpa_pkg::fpa_cls_type q_data,
   input  logic                 q_empty,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output fpa_pkg::fpa_rsp_type rsp_data
);

   localparam int H = FRAC / 2;
   localparam logic [31:0] MUL_LIMIT = 32'h7FFF_FFFF >> FRAC;
   localparam logic [31:0] LOW_MASK  = 32'((64'd1 << H) - 64'd1);

   logic                 en;
   logic                 p1_valid_ff;
   fpa_pkg::fpa_cls_type p1_ff;
   logic                 p2_valid_ff;
   fpa_pkg::fpa_cls_type p2_ff;
   logic [63:0]          prod_ff;
   logic [63:0]          hh_ff;
   logic [63:0]          hl_ff;
   logic [63:0]          lh_ff;
   logic [63:0]          ll_ff;
   logic [31:0]          ah;
   logic [31:0]          al;
   logic [31:0]          bh;
   logic [31:0]          bl;
   logic [63:0]          pp_sum;
   logic [31:0]          mag32;
   fpa_pkg::fpa_side_type side1;
   logic [31:0]          dividend1;
   logic                 v1;
   logic [31:0]          q1;
   logic [31:0]          r1;
   logic [31:0]          d1;
   fpa_pkg::fpa_side_type side_a;
   fpa_pkg::fpa_side_type side2;
   logic [31:0]          x2;
   logic                 v2;
   logic [31:0]          f2;
   fpa_pkg::fpa_side_type side_b;
   logic [fpa_pkg::SHIFT_W-1:0] frac_sh;
   logic [31:0]          q_fin;
   logic [31:0]          res_fin;
   logic                 rsp_valid_ff;
   fpa_pkg::fpa_rsp_type rsp_ff;

   // freeze the whole back end while a finished item waits
   assign en    = !(rsp_valid_ff && rsp_stall);
   assign q_pop = en && !q_empty;

   assign ah = p1_ff.ua >> H;
   assign al = p1_ff.ua & LOW_MASK;
   assign bh = p1_ff.ub >> H;
   assign bl = p1_ff.ub & LOW_MASK;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= q_pop;
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff   <= q_data;
         p2_ff   <= p1_ff;
         prod_ff <= 64'(p1_ff.ua) * 64'(p1_ff.ub);
         hh_ff   <= 64'(ah) * 64'(bh);
         hl_ff   <= 64'(ah) * 64'(bl);
         lh_ff   <= 64'(al) * 64'(bh);
         ll_ff   <= 64'(al) * 64'(bl);
      end
   end

   assign pp_sum = hh_ff + (hl_ff >> H) + (lh_ff >> H) + (ll_ff >> FRAC);
   assign mag32  = pp_sum[31:0];

   always_comb begin
      side1.result = p2_ff.result;
      side1.status = p2_ff.status;
      side1.lt     = p2_ff.lt;
      side1.eq     = p2_ff.eq;
      side1.gt     = p2_ff.gt;
      side1.is_div = p2_ff.is_div;
      side1.s_ge   = p2_ff.s >= fpa_pkg::SHIFT_W'(FRAC);
      side1.s      = p2_ff.s;
      side1.neg    = p2_ff.neg;
      if (p2_ff.is_mul) begin
         // |a|*|b| above the limit is the same test as |b| > limit/|a|
         if (prod_ff > {32'd0, MUL_LIMIT}) begin
            side1.status = fpa_pkg::ST_OVF;
            side1.result = p2_ff.a;
         end else begin
            side1.result = p2_ff.neg ? (32'd0 - mag32) : mag32;
         end
      end
      dividend1 = side1.s_ge ? (p2_ff.ua << FRAC) : p2_ff.ua;
   end

   fpa_div_pipe #(.STEPS(32)) u_div_main (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (p2_valid_ff),
      .in_dividend  (dividend1),
      .in_divisor   (p2_ff.ub),
      .in_side      (side1),
      .out_valid    (v1),
      .out_quotient (q1),
      .out_remainder(r1),
      .out_divisor  (d1),
      .out_side     (side_a)
   );

   // hold the first quotient in the result slot through the fraction pass
   always_comb begin
      side2 = side_a;
      if (side_a.is_div) side2.result = q1;
      x2 = r1 << side_a.s;
   end

   fpa_div_pipe #(.STEPS(FRAC)) u_div_frac (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (v1),
      .in_dividend  (x2),
      .in_divisor   (d1),
      .in_side      (side2),
      .out_valid    (v2),
      .out_quotient (f2),
      .out_remainder(),
      .out_divisor  (),
      .out_side     (side_b)
   );

   assign frac_sh = fpa_pkg::SHIFT_W'(FRAC) - side_b.s;

   always_comb begin
      q_fin   = side_b.s_ge ? side_b.result
                            : (side_b.result << FRAC) + (f2 << frac_sh);
      res_fin = side_b.result;
      if (side_b.is_div) res_fin = side_b.neg ? (32'd0 - q_fin) : q_fin;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v2;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff.result_value <= res_fin;
         rsp_ff.less_than    <= side_b.lt;
         rsp_ff.equal_to     <= side_b.eq;
         rsp_ff.greater_than <= side_b.gt;
         rsp_ff.status       <= side_b.status;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire
